/* design/lbpv_pkg.sv */
// ----------------------------------------------------------------------------
// lbpv_pkg: shared types and constants for the light bar pair validator
// Field widths, configuration register codes, verdict codes and helpers.
// ----------------------------------------------------------------------------
package lbpv_pkg;

    localparam int COORD_BITS  = 14;
    localparam int ANGLE_BITS  = 12;
    localparam int TOL_BITS    = 12;
    localparam int MARGIN_BITS = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = (TOL_BITS > MARGIN_BITS) ? TOL_BITS : MARGIN_BITS;

    // signed span bounds: coordinate plus or minus margin, with a sign bit
    localparam int SPAN_W = ((COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS) + 2;
    localparam int SQ_W   = 2 * COORD_BITS;

    localparam logic [TOL_BITS-1:0]    ANGLE_TOL_RESET = TOL_BITS'(200);
    localparam logic [MARGIN_BITS-1:0] VERT_MARGIN_RESET = MARGIN_BITS'(40);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ANGLE_TOL   = 2'd0,
        CFG_VERT_MARGIN = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        VERDICT_VALID      = 3'd0,
        VERDICT_ANGLE      = 3'd1,
        VERDICT_HEIGHT     = 3'd2,
        VERDICT_VERTICAL   = 3'd3,
        VERDICT_PROPORTION = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [TOL_BITS-1:0]    angle_tolerance;
        logic [MARGIN_BITS-1:0] vertical_margin;
    } t_cfg;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] first_angle;
        logic [COORD_BITS-1:0]        first_height;
        logic [COORD_BITS-1:0]        first_top_x;
        logic [COORD_BITS-1:0]        first_top_y;
        logic [COORD_BITS-1:0]        first_bottom_x;
        logic [COORD_BITS-1:0]        first_bottom_y;
        logic signed [ANGLE_BITS-1:0] second_angle;
        logic [COORD_BITS-1:0]        second_height;
        logic [COORD_BITS-1:0]        second_top_x;
        logic [COORD_BITS-1:0]        second_top_y;
        logic [COORD_BITS-1:0]        second_bottom_x;
        logic [COORD_BITS-1:0]        second_bottom_y;
    } t_pair;

    function automatic logic [COORD_BITS-1:0] f_abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

/* design/lbpv_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lbpv_cfg_regs: configuration registers
// Holds the angle tolerance and vertical margin; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module lbpv_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lbpv_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lbpv_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output lbpv_pkg::t_cfg                      o_cfg
);

    lbpv_pkg::t_cfg r_cfg;
    lbpv_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbpv_pkg::CFG_ANGLE_TOL: begin
                    n_cfg.angle_tolerance = i_cfg_data[lbpv_pkg::TOL_BITS-1:0];
                end
                lbpv_pkg::CFG_VERT_MARGIN: begin
                    n_cfg.vertical_margin = i_cfg_data[lbpv_pkg::MARGIN_BITS-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_tolerance <= lbpv_pkg::ANGLE_TOL_RESET;
            r_cfg.vertical_margin <= lbpv_pkg::VERT_MARGIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* design/lbpv_check.sv */
// ----------------------------------------------------------------------------
// lbpv_check: pair tests
// Runs angle, height ratio, vertical overlap and proportion tests in parallel
// and picks the first failure as the verdict.
// ----------------------------------------------------------------------------
module lbpv_check (
    input  lbpv_pkg::t_pair    i_pair,
    input  lbpv_pkg::t_cfg     i_cfg,
    output lbpv_pkg::t_verdict o_verdict
);

    localparam int CB = lbpv_pkg::COORD_BITS;
    localparam int AB = lbpv_pkg::ANGLE_BITS;
    localparam int SW = lbpv_pkg::SPAN_W;
    localparam int QW = lbpv_pkg::SQ_W;

    // angle
    logic signed [AB:0] angle_diff;
    logic [AB:0]        angle_mag;
    logic               angle_ok;

    // height ratio
    logic [CB:0]   h1_x2;
    logic [CB+1:0] h2_x3;
    logic          height_ok;

    // vertical overlap
    logic signed [SW-1:0] margin_s;
    logic signed [SW-1:0] top1, bot1, top2, bot2;
    logic                 vert_ok;

    // proportion
    logic [CB-1:0] d_tx, d_ty, d_bx, d_by, h_max;
    logic [QW-1:0] sq_tx, sq_ty, sq_bx, sq_by, sq_h;
    logic [QW:0]   dist_top, dist_bot, dist_max;
    logic          prop_ok;

    assign angle_diff = {i_pair.first_angle[AB-1], i_pair.first_angle}
                      - {i_pair.second_angle[AB-1], i_pair.second_angle};
    assign angle_mag  = angle_diff[AB] ? (AB+1)'(-angle_diff) : (AB+1)'(angle_diff);
    assign angle_ok   = angle_mag < {1'b0, i_cfg.angle_tolerance};

    assign h1_x2     = {i_pair.first_height, 1'b0};
    assign h2_x3     = {1'b0, i_pair.second_height, 1'b0} + {2'b00, i_pair.second_height};
    assign height_ok = (h1_x2 > {1'b0, i_pair.second_height}) && ({1'b0, h1_x2} < h2_x3);

    assign margin_s = $signed({{(SW-lbpv_pkg::MARGIN_BITS){1'b0}}, i_cfg.vertical_margin});
    assign top1 = $signed({{(SW-CB){1'b0}}, i_pair.first_top_y}) - margin_s;
    assign bot1 = $signed({{(SW-CB){1'b0}}, i_pair.first_bottom_y}) + margin_s;
    assign top2 = $signed({{(SW-CB){1'b0}}, i_pair.second_top_y}) - margin_s;
    assign bot2 = $signed({{(SW-CB){1'b0}}, i_pair.second_bottom_y}) + margin_s;

    // bounds inclusive; inverted spans are left as they are
    assign vert_ok = ((top2 >= top1) && (top2 <= bot1))
                  || ((bot2 >= top1) && (bot2 <= bot1))
                  || ((top1 >= top2) && (top1 <= bot2))
                  || ((bot1 >= top2) && (bot1 <= bot2));

    assign d_tx = lbpv_pkg::f_abs_diff(i_pair.first_top_x, i_pair.second_top_x);
    assign d_ty = lbpv_pkg::f_abs_diff(i_pair.first_top_y, i_pair.second_top_y);
    assign d_bx = lbpv_pkg::f_abs_diff(i_pair.first_bottom_x, i_pair.second_bottom_x);
    assign d_by = lbpv_pkg::f_abs_diff(i_pair.first_bottom_y, i_pair.second_bottom_y);
    assign h_max = (i_pair.first_height > i_pair.second_height)
                 ? i_pair.first_height : i_pair.second_height;

    assign sq_tx = QW'(d_tx) * QW'(d_tx);
    assign sq_ty = QW'(d_ty) * QW'(d_ty);
    assign sq_bx = QW'(d_bx) * QW'(d_bx);
    assign sq_by = QW'(d_by) * QW'(d_by);
    assign sq_h  = QW'(h_max) * QW'(h_max);

    assign dist_top = {1'b0, sq_tx} + {1'b0, sq_ty};
    assign dist_bot = {1'b0, sq_bx} + {1'b0, sq_by};
    assign dist_max = (dist_top > dist_bot) ? dist_top : dist_bot;
    assign prop_ok  = !({1'b0, sq_h} > dist_max);

    always_comb begin
        if (!angle_ok) begin
            o_verdict = lbpv_pkg::VERDICT_ANGLE;
        end else if (!height_ok) begin
            o_verdict = lbpv_pkg::VERDICT_HEIGHT;
        end else if (!vert_ok) begin
            o_verdict = lbpv_pkg::VERDICT_VERTICAL;
        end else if (!prop_ok) begin
            o_verdict = lbpv_pkg::VERDICT_PROPORTION;
        end else begin
            o_verdict = lbpv_pkg::VERDICT_VALID;
        end
    end

endmodule

/* design/light_bar_pair_validator.sv */
// ----------------------------------------------------------------------------
// light_bar_pair_validator: top level
// Registers a pair of light bars, runs the pair tests and registers the verdict.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    first_* and second_* bar fields
// out       output     o_out_valid / i_out_stall  o_verdict
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction per cycle while the output is not stalled; an accepted pair is
// held in the input register, then its verdict shows at the result (output) register.
// Reset is synchronous, active low; it empties both stages and loads the
// register defaults (tolerance 200, margin 40).
// A stalled output holds its verdict; the input stalls only when both stages
// are full and the output is stalled.
// ----------------------------------------------------------------------------
module light_bar_pair_validator (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,

    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic signed [lbpv_pkg::ANGLE_BITS-1:0]     i_first_angle,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_first_height,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_first_top_x,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_first_top_y,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_first_bottom_x,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_first_bottom_y,
    input  logic signed [lbpv_pkg::ANGLE_BITS-1:0]     i_second_angle,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_second_height,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_second_top_x,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_second_top_y,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_second_bottom_x,
    input  logic [lbpv_pkg::COORD_BITS-1:0]            i_second_bottom_y,

    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic [2:0]                                 o_verdict,

    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [lbpv_pkg::CFG_IDX_BITS-1:0]          i_cfg_index,
    input  logic [lbpv_pkg::CFG_DATA_BITS-1:0]         i_cfg_data
);

    lbpv_pkg::t_cfg     cfg;
    lbpv_pkg::t_pair    in_pair;
    lbpv_pkg::t_verdict verdict;

    lbpv_pkg::t_pair    r_pair;
    logic               r_pair_vld;
    lbpv_pkg::t_verdict r_verdict;
    logic               r_out_vld;

    logic adv_out;
    logic adv_in;
    logic in_accept;

    lbpv_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign in_pair.first_angle     = i_first_angle;
    assign in_pair.first_height    = i_first_height;
    assign in_pair.first_top_x     = i_first_top_x;
    assign in_pair.first_top_y     = i_first_top_y;
    assign in_pair.first_bottom_x  = i_first_bottom_x;
    assign in_pair.first_bottom_y  = i_first_bottom_y;
    assign in_pair.second_angle    = i_second_angle;
    assign in_pair.second_height   = i_second_height;
    assign in_pair.second_top_x    = i_second_top_x;
    assign in_pair.second_top_y    = i_second_top_y;
    assign in_pair.second_bottom_x = i_second_bottom_x;
    assign in_pair.second_bottom_y = i_second_bottom_y;

    lbpv_check u_check (
        .i_pair    (r_pair),
        .i_cfg     (cfg),
        .o_verdict (verdict)
    );

    // advance a stage when the stage after it is empty or draining
    assign adv_out   = !r_out_vld || !i_out_stall;
    assign adv_in    = !r_pair_vld || adv_out;
    assign in_accept = i_in_valid && adv_in;

    assign o_in_stall  = !adv_in;
    assign o_out_valid = r_out_vld;
    assign o_verdict   = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (adv_in) begin
                r_pair_vld <= i_in_valid;
            end
            if (adv_out) begin
                r_out_vld <= r_pair_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pair <= in_pair;
        end
        if (adv_out && r_pair_vld) begin
            r_verdict <= verdict;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_pair_vld && r_out_vld && i_out_stall))
        else $error("input stalled while pipeline has room");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_pair_vld)
        else $error("accepted transaction lost in input stage");

    a_stage_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pair_vld && adv_out) |=> r_out_vld)
        else $error("transaction lost between stages");

    a_verdict_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (o_verdict == lbpv_pkg::VERDICT_VALID
                    || o_verdict == lbpv_pkg::VERDICT_ANGLE
                    || o_verdict == lbpv_pkg::VERDICT_HEIGHT
                    || o_verdict == lbpv_pkg::VERDICT_VERTICAL
                    || o_verdict == lbpv_pkg::VERDICT_PROPORTION))
        else $error("verdict code out of range");

endmodule
